// File: rtl/core/wprr_pkg.sv
// Package for the weighted priority round-robin core: types, codes, constants.
// No dependencies; every module of the core imports it.
`timescale 1ns / 1ps
package wprr_pkg;

   localparam int MAX_TASKS_DEF  = 64;
   localparam int NUM_LEVELS_DEF = 5;
   localparam int NUM_SLOTS_DEF  = 10;
   localparam logic [29:0] SLOT_RESET = 30'd172865828;

   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_REMOVE  = 3'd1,
      OP_BLOCK   = 3'd2,
      OP_UNBLOCK = 3'd3,
      OP_SETPRIO = 3'd4,
      OP_SCHED   = 3'd5
   } op_type;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_REJECTED = 2'd1;
   localparam logic [1:0] ST_NONE     = 2'd2;

   typedef struct packed {
      logic [2:0] operation;
      logic [5:0] task_id;
      logic [2:0] level;
   } req_word_type;

   typedef struct packed {
      logic [5:0] picked_task;
      logic [1:0] status;
      logic       idle_pick;
      logic [6:0] runnable_count;
   } rsp_word_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_UNLINK,
      S_UNLINK_FIX,
      S_APPEND,
      S_WALK,
      S_WALK_READ,
      S_FINISH,
      S_OUT
   } state_type;

endpackage

// File: rtl/core/wprr_link_ram.sv
// Link memory of the task entries: one write port, one registered read port.
// Depends on wprr_pkg for the default depth and the house import.
`timescale 1ns / 1ps
module wprr_link_ram #(
   parameter int DEPTH = wprr_pkg::MAX_TASKS_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [AW:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [AW:0]   rd_data
);
   import wprr_pkg::*;

   logic [AW:0] mem [DEPTH];

   // Read data is registered; a read in the cycle of a write to the same
   // address returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/core/weighted_priority_round_robin_core.sv
// Top level of the weighted priority round-robin task picker.
// Depends on wprr_pkg and wprr_link_ram.
//
// Usage: request words arrive on req_valid/req_ready carrying operation,
// task_id and level; one response word per request leaves on
// rsp_valid/rsp_ready. The slot table is written through csr_wr_en and
// csr_wr_data; the user must write it only while the core is idle, as
// the core does not enforce this. Block, unblock and rejected words need
// no list walk. Remove, and set priority to a new level, search the
// task's list, following one link from the registered link memory port
// per entry that precedes the task. Schedule may visit NUM_SLOTS+1
// lists. One request is handled at a time; the next can be accepted
// from the cycle after the response is taken.
// Reset clears all valid and blocked flags, list heads, tails, cursors,
// lengths, slot pointer and runnable count; the link and level memories
// are not cleared and are only used for valid entries.
// When the receiver stalls the response is held in the output register
// and the next request is refused until it has been taken.
`timescale 1ns / 1ps
module weighted_priority_round_robin_core #(
   parameter int MAX_TASKS  = wprr_pkg::MAX_TASKS_DEF,
   parameter int NUM_LEVELS = wprr_pkg::NUM_LEVELS_DEF,
   parameter int NUM_SLOTS  = wprr_pkg::NUM_SLOTS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  wprr_pkg::req_word_type    req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output wprr_pkg::rsp_word_type    rsp_word,
   input  logic                      csr_wr_en,
   input  logic [3*NUM_SLOTS-1:0]    csr_wr_data
);
   import wprr_pkg::*;

   localparam int AW = $clog2(MAX_TASKS);
   localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);
   localparam int GW = $clog2(MAX_TASKS + NUM_SLOTS + 2) + 1;
   localparam logic [AW:0] NIL = {1'b1, AW'(0)};
   localparam logic [2:0] TOP_LEVEL = 3'(NUM_LEVELS - 1);

   // Configuration register.
   logic [3*NUM_SLOTS-1:0] slots_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= (3*NUM_SLOTS)'(SLOT_RESET);
      end else if (csr_wr_en) begin
         slots_ff <= csr_wr_data;
      end
   end

   // Per-entry flags and level, per-list registers.
   logic [MAX_TASKS-1:0] valid_ff, blocked_ff;
   logic [LW-1:0]        lvl_ff [MAX_TASKS];
   logic [AW:0]          head_ff [NUM_LEVELS];
   logic [AW:0]          tail_ff [NUM_LEVELS];
   logic [AW:0]          cur_ff  [NUM_LEVELS];
   logic [CW-1:0]        len_ff  [NUM_LEVELS];
   logic [SW-1:0]        sp_ff;
   logic [CW-1:0]        tally_ff;

   // Sequencer registers.
   state_type     state_ff;
   req_word_type  req_ff;
   logic [LW-1:0] tlv_ff;
   logic [AW:0]   prev_ff, walk_ff;
   logic [LW-1:0] lv_ff;
   logic          was_ff;
   logic [GW-1:0] adv_ff;
   logic [CW-1:0] guard_ff;
   logic          counted_ff;
   rsp_word_type  rsp_ff;
   logic          rsp_valid_ff;

   // Link memory port.
   logic          lk_we;
   logic [AW-1:0] lk_wa, lk_ra;
   logic [AW:0]   lk_wd, lk_rd;
   logic          fix_new_ff;

   wprr_link_ram #(.DEPTH(MAX_TASKS), .AW(AW)) u_link (
      .clock  (clock),
      .wr_en  (lk_we),
      .wr_addr(lk_wa),
      .wr_data(lk_wd),
      .rd_addr(lk_ra),
      .rd_data(lk_rd)
   );

   // Slot level lookup with clamping.
   function automatic logic [LW-1:0] slot_lv(input logic [3*NUM_SLOTS-1:0] tbl,
                                             input logic [SW-1:0] s);
      logic [2:0] v;
      v = tbl[3*s +: 3];
      if (v > TOP_LEVEL) v = TOP_LEVEL;
      return LW'(v);
   endfunction

   logic [AW-1:0] tid;
   logic [LW-1:0] tlv;
   logic          tcount;
   assign tid    = req_ff.task_id[AW-1:0];
   assign tlv    = tlv_ff;
   assign tcount = valid_ff[tid] && (tlv != '0) && !blocked_ff[tid];

   logic [SW-1:0] sp_next;
   assign sp_next = (sp_ff == SW'(NUM_SLOTS - 1)) ? '0 : sp_ff + 1'b1;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   logic id_ok;
   assign id_ok = (32'(req_ff.task_id) < MAX_TASKS);

   // Sequencer and state updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         blocked_ff   <= '0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= NIL;
            tail_ff[i] <= NIL;
            cur_ff[i]  <= NIL;
            len_ff[i]  <= '0;
         end
         sp_ff        <= '0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff   <= req_word;
                  // Registered read of the level memory for the new word.
                  tlv_ff   <= lvl_ff[req_word.task_id[AW-1:0]];
                  rsp_ff   <= '0;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               counted_ff <= tcount;
               guard_ff   <= '0;
               prev_ff    <= NIL;
               was_ff     <= 1'b1;
               adv_ff     <= '0;
               lv_ff      <= slot_lv(slots_ff, sp_ff);
               state_ff   <= S_FINISH;
               if (req_ff.operation == OP_SCHED) begin
                  if (tally_ff == '0) begin
                     if (len_ff[0] != '0 && !head_ff[0][AW]) begin
                        rsp_ff.picked_task <= 6'(head_ff[0][AW-1:0]);
                        rsp_ff.idle_pick   <= 1'b1;
                     end else begin
                        rsp_ff.status <= ST_NONE;
                     end
                  end else begin
                     state_ff <= S_WALK;
                  end
               end else if (req_ff.operation > OP_SCHED || !id_ok) begin
                  rsp_ff.status <= ST_REJECTED;
               end else if (req_ff.operation == OP_ADD) begin
                  if (tid == '0 || valid_ff[tid] || req_ff.level > TOP_LEVEL) begin
                     rsp_ff.status <= ST_REJECTED;
                  end else begin
                     valid_ff[tid]   <= 1'b1;
                     blocked_ff[tid] <= 1'b0;
                     lvl_ff[tid]     <= LW'(req_ff.level);
                     tlv_ff          <= LW'(req_ff.level);
                     state_ff        <= S_APPEND;
                  end
               end else if (!valid_ff[tid]) begin
                  rsp_ff.status <= ST_REJECTED;
               end else if (req_ff.operation == OP_REMOVE) begin
                  walk_ff  <= head_ff[tlv];
                  lv_ff    <= tlv;
                  state_ff <= S_UNLINK;
               end else if (req_ff.operation == OP_BLOCK) begin
                  blocked_ff[tid] <= 1'b1;
               end else if (req_ff.operation == OP_UNBLOCK) begin
                  blocked_ff[tid] <= 1'b0;
               end else if (req_ff.task_id < 6'd3 || req_ff.level > TOP_LEVEL) begin
                  rsp_ff.status <= ST_REJECTED;
               end else if (LW'(req_ff.level) != tlv) begin
                  walk_ff  <= head_ff[tlv];
                  lv_ff    <= tlv;
                  state_ff <= S_UNLINK;
               end
            end
            // Search the list for the task, following one link per pass through S_WALK_READ.
            S_UNLINK: begin
               if (walk_ff[AW] || walk_ff == {1'b0, tid} ||
                   guard_ff == CW'(MAX_TASKS)) begin
                  state_ff <= (walk_ff == {1'b0, tid}) ? S_UNLINK_FIX : S_FINISH;
               end else begin
                  state_ff <= S_WALK_READ;
               end
            end
            S_UNLINK_FIX: begin
               if (len_ff[lv_ff] == CW'(1) || len_ff[lv_ff] == '0) begin
                  head_ff[lv_ff] <= NIL;
                  tail_ff[lv_ff] <= NIL;
               end else begin
                  if (prev_ff[AW]) head_ff[lv_ff] <= lk_rd;
                  if (tail_ff[lv_ff] == {1'b0, tid}) tail_ff[lv_ff] <= prev_ff;
               end
               if (len_ff[lv_ff] != '0) len_ff[lv_ff] <= len_ff[lv_ff] - 1'b1;
               if (cur_ff[lv_ff] == {1'b0, tid}) cur_ff[lv_ff] <= NIL;
               if (req_ff.operation == OP_REMOVE) begin
                  valid_ff[tid]   <= 1'b0;
                  blocked_ff[tid] <= 1'b0;
                  state_ff        <= S_FINISH;
               end else begin
                  lvl_ff[tid] <= LW'(req_ff.level);
                  tlv_ff      <= LW'(req_ff.level);
                  state_ff    <= S_APPEND;
               end
            end
            S_APPEND: begin
               if (len_ff[LW'(req_ff.level)] == '0 || tail_ff[LW'(req_ff.level)][AW])
                  head_ff[LW'(req_ff.level)] <= {1'b0, tid};
               tail_ff[LW'(req_ff.level)] <= {1'b0, tid};
               len_ff[LW'(req_ff.level)]  <= len_ff[LW'(req_ff.level)] + 1'b1;
               state_ff <= S_FINISH;
            end
            // One step of the schedule walk over the current list.
            S_WALK: begin
               if (len_ff[lv_ff] == '0 || head_ff[lv_ff][AW]) begin
                  adv_ff <= adv_ff + 1'b1;
                  sp_ff  <= sp_next;
                  lv_ff  <= slot_lv(slots_ff, sp_next);
                  was_ff <= 1'b1;
                  if (adv_ff == GW'(NUM_SLOTS)) begin
                     rsp_ff.status <= ST_NONE;
                     state_ff      <= S_OUT;
                  end
               end else if (cur_ff[lv_ff][AW]) begin
                  cur_ff[lv_ff] <= head_ff[lv_ff];
                  was_ff        <= 1'b1;
                  if (!blocked_ff[head_ff[lv_ff][AW-1:0]]) begin
                     rsp_ff.picked_task <= 6'(head_ff[lv_ff][AW-1:0]);
                     state_ff           <= S_OUT;
                  end
               end else begin
                  state_ff <= S_WALK_READ;
               end
            end
            S_WALK_READ: begin
               if (req_ff.operation != OP_SCHED) begin
                  // Unlink search step: follow the link just read.
                  prev_ff  <= walk_ff;
                  walk_ff  <= lk_rd;
                  guard_ff <= guard_ff + 1'b1;
                  state_ff <= S_UNLINK;
               end else if (lk_rd[AW]) begin
                  if (!was_ff && !blocked_ff[cur_ff[lv_ff][AW-1:0]]) begin
                     rsp_ff.picked_task <= 6'(cur_ff[lv_ff][AW-1:0]);
                     state_ff           <= S_OUT;
                  end else begin
                     cur_ff[lv_ff] <= NIL;
                     adv_ff <= adv_ff + 1'b1;
                     sp_ff  <= sp_next;
                     lv_ff  <= slot_lv(slots_ff, sp_next);
                     was_ff <= 1'b1;
                     state_ff <= S_WALK;
                     if (adv_ff == GW'(NUM_SLOTS)) begin
                        rsp_ff.status <= ST_NONE;
                        state_ff      <= S_OUT;
                     end
                  end
               end else begin
                  cur_ff[lv_ff] <= lk_rd;
                  was_ff        <= 1'b0;
                  if (!blocked_ff[lk_rd[AW-1:0]]) begin
                     rsp_ff.picked_task <= 6'(lk_rd[AW-1:0]);
                     state_ff           <= S_OUT;
                  end else begin
                     state_ff <= S_WALK;
                  end
               end
            end
            // Fix the runnable count for the concerned task.
            S_FINISH: begin
               if (req_ff.operation != OP_SCHED && req_ff.operation <= OP_SETPRIO
                   && id_ok) begin
                  tally_ff <= tally_ff - CW'(counted_ff) + CW'(tcount);
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_ff.runnable_count <= 7'(tally_ff);
               rsp_valid_ff          <= 1'b1;
               state_ff              <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Link memory control: appends link in the new tail, unlinks patch prev.
   always_comb begin
      lk_we = 1'b0;
      lk_wa = tid;
      lk_wd = NIL;
      lk_ra = tid;
      if (state_ff == S_UNLINK) begin
         lk_ra = walk_ff[AW-1:0];
      end else if (state_ff == S_WALK) begin
         lk_ra = cur_ff[lv_ff][AW-1:0];
      end
      if (state_ff == S_UNLINK_FIX && !prev_ff[AW] && len_ff[lv_ff] > CW'(1)) begin
         lk_we = 1'b1;
         lk_wa = prev_ff[AW-1:0];
         lk_wd = lk_rd;
      end else if (state_ff == S_APPEND) begin
         if (len_ff[LW'(req_ff.level)] == '0 || tail_ff[LW'(req_ff.level)][AW]) begin
            lk_we = 1'b1;
            lk_wa = tid;
            lk_wd = NIL;
         end else begin
            lk_we = 1'b1;
            lk_wa = tail_ff[LW'(req_ff.level)][AW-1:0];
            lk_wd = {1'b0, tid};
         end
      end else if (fix_new_ff) begin
         lk_we = 1'b1;
         lk_wa = tid;
         lk_wd = NIL;
      end
   end

   // The new task's own link is cleared in the cycle after its tail patch.
   always_ff @(posedge clock) begin
      if (reset) fix_new_ff <= 1'b0;
      else       fix_new_ff <= lk_we && state_ff == S_APPEND && !lk_wd[AW];
   end

`ifndef ASSERT_OFF
   // A response is only raised by the output state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("response raised outside output state");
   // The runnable count never exceeds the task count.
   assert property (@(posedge clock) disable iff (reset)
      32'(tally_ff) <= MAX_TASKS)
      else $error("runnable count out of range");
   // The slot pointer stays within the table.
   assert property (@(posedge clock) disable iff (reset)
      32'(sp_ff) < NUM_SLOTS)
      else $error("slot pointer out of range");
`endif
endmodule
